// ===== hw/rtl/rrsp_pkg.sv =====
// rrsp_pkg: types and constants shared by the round robin slave poller
// no dependencies; used by rrsp_engine, round_robin_slave_poller, rrsp_checker and the testbench

package rrsp_pkg;

  localparam int MAX_SLAVES_DEF  = 8;
  localparam int LENGTH_BITS_DEF = 16;

  localparam int LEN_W     = 16;
  localparam int ADDR_W    = 8;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 4;
  localparam int TABLE_N   = 8;
  localparam int TSEL_W    = $clog2(TABLE_N);
  localparam int LIST_W    = TABLE_N * ADDR_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = LIST_W;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_REPLY   = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLL_ENABLE   = 2'd0,
    REG_SLAVE_COUNT   = 2'd1,
    REG_ROUND_INTERVAL = 2'd2,
    REG_ADDRESS_LIST  = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SEND = 3'b010,
    PH_WAIT = 3'b100
  } phase_e;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [TIME_W-1:0] now_ms;
    logic              reply_accepted;
    logic [LEN_W-1:0]  reply_length;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] slave_address;
    logic              slave_online;
    logic [LEN_W-1:0]  report_length;
  } out_item_t;

  typedef struct packed {
    logic               poll_enable;
    logic [COUNT_W-1:0] slave_count;
    logic [TIME_W-1:0]  round_interval;
    logic [LIST_W-1:0]  slave_address_list;
  } cfg_t;

endpackage

// ===== hw/rtl/rrsp_engine.sv =====
// rrsp_engine: poll state machine, one input beat per step, at most one result
// depends on rrsp_pkg

module rrsp_engine #(
  parameter int MAX_SLAVES  = rrsp_pkg::MAX_SLAVES_DEF,
  parameter int LENGTH_BITS = rrsp_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  rrsp_pkg::in_item_t  item_i,
  input  rrsp_pkg::cfg_t      cfg_i,
  output logic                res_valid_o,
  output rrsp_pkg::out_item_t res_o
);

  localparam int CountW = rrsp_pkg::COUNT_W;
  localparam int TimeW  = rrsp_pkg::TIME_W;
  localparam int LenW   = rrsp_pkg::LEN_W;
  localparam int AddrW  = rrsp_pkg::ADDR_W;
  localparam int TselW  = rrsp_pkg::TSEL_W;
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_SLAVES);

  rrsp_pkg::phase_e         phase_q, phase_d;
  logic [CountW-1:0]        idx_q, idx_d;
  logic [TimeW-1:0]         end_q, end_d;
  logic                     seen_q, seen_d;
  logic                     online_q, online_d;
  logic [LENGTH_BITS-1:0]   len_q, len_d;

  logic [CountW-1:0]        count;
  logic [CountW-1:0]        idx_inc;
  logic [TimeW-1:0]         elapsed;
  logic [AddrW-1:0]         cur_addr;

  assign count    = (cfg_i.slave_count > MaxCount) ? MaxCount : cfg_i.slave_count;
  assign idx_inc  = idx_q + CountW'(1);
  assign elapsed  = item_i.now_ms - end_q;
  assign cur_addr = cfg_i.slave_address_list[idx_q[TselW-1:0]*AddrW +: AddrW];

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    end_d       = end_q;
    seen_d      = seen_q;
    online_d    = online_q;
    len_d       = len_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i && cfg_i.poll_enable) begin
      unique case (item_i.opcode)
        rrsp_pkg::OP_RESTART: begin
          idx_d   = '0;
          phase_d = rrsp_pkg::PH_IDLE;
          seen_d  = 1'b0;
          end_d   = item_i.now_ms;
        end
        rrsp_pkg::OP_REPLY: begin
          if (phase_q == rrsp_pkg::PH_WAIT && !seen_q && item_i.reply_accepted) begin
            seen_d   = 1'b1;
            online_d = 1'b1;
            len_d    = item_i.reply_length[LENGTH_BITS-1:0];
          end
        end
        rrsp_pkg::OP_TIMEOUT: begin
          if (phase_q == rrsp_pkg::PH_WAIT && !seen_q) begin
            seen_d   = 1'b1;
            online_d = 1'b0;
            len_d    = '0;
          end
        end
        default: begin
          if (count != '0) begin
            unique case (phase_q)
              rrsp_pkg::PH_SEND: begin
                if (idx_q >= count) begin
                  end_d   = item_i.now_ms;
                  phase_d = rrsp_pkg::PH_IDLE;
                end else begin
                  res_valid_o         = 1'b1;
                  res_o.result_kind   = rrsp_pkg::KIND_REQUEST;
                  res_o.slave_address = cur_addr;
                  seen_d              = 1'b0;
                  phase_d             = rrsp_pkg::PH_WAIT;
                end
              end
              rrsp_pkg::PH_WAIT: begin
                if (seen_q) begin
                  res_valid_o         = 1'b1;
                  res_o.result_kind   = rrsp_pkg::KIND_REPORT;
                  res_o.slave_address = cur_addr;
                  res_o.slave_online  = online_q;
                  res_o.report_length = LenW'(len_q);
                  idx_d               = idx_inc;
                  if (idx_inc < count) begin
                    phase_d = rrsp_pkg::PH_SEND;
                  end else begin
                    end_d   = item_i.now_ms;
                    phase_d = rrsp_pkg::PH_IDLE;
                  end
                end
              end
              default: begin
                if (elapsed >= cfg_i.round_interval) begin
                  idx_d   = '0;
                  phase_d = rrsp_pkg::PH_SEND;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rrsp_pkg::PH_IDLE;
      idx_q    <= '0;
      end_q    <= '0;
      seen_q   <= 1'b0;
      online_q <= 1'b0;
      len_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      end_q    <= end_d;
      seen_q   <= seen_d;
      online_q <= online_d;
      len_q    <= len_d;
    end
  end

endmodule

// ===== hw/rtl/round_robin_slave_poller.sv =====
// round_robin_slave_poller: top level with config registers, input and result registers
// depends on rrsp_pkg and rrsp_engine

// The poller takes one event beat per cycle (tick, reply, timeout or restart) and
// answers with at most one result beat: a status request when a slave is due, or a
// report with its online state and reply length on the tick after its reply or timeout.
// Each beat is held in the input register while the engine works on it, and its result
// is then written to the result register; the engine's state update is the only loop,
// so beats stream at one per cycle while the result register drains. in_stall_o rises
// only while a result waits under out_stall_i.
// Configuration writes take effect at once and are meant for an idle poller.

module round_robin_slave_poller #(
  parameter int MAX_SLAVES  = rrsp_pkg::MAX_SLAVES_DEF,
  parameter int LENGTH_BITS = rrsp_pkg::LENGTH_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  rrsp_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output rrsp_pkg::out_item_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [rrsp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rrsp_pkg::CFG_DW-1:0]        cfg_wdata_i
);

  rrsp_pkg::cfg_t      cfg_q;
  logic                in_valid_q;
  rrsp_pkg::in_item_t  in_q;
  logic                out_valid_q;
  rrsp_pkg::out_item_t out_q;

  logic                advance;
  logic                accept;
  logic                step;
  logic                res_valid;
  rrsp_pkg::out_item_t res;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign step       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rrsp_pkg::REG_POLL_ENABLE:    cfg_q.poll_enable <= cfg_wdata_i[0];
        rrsp_pkg::REG_SLAVE_COUNT:    cfg_q.slave_count <= cfg_wdata_i[rrsp_pkg::COUNT_W-1:0];
        rrsp_pkg::REG_ROUND_INTERVAL: cfg_q.round_interval <= cfg_wdata_i[rrsp_pkg::TIME_W-1:0];
        default:                      cfg_q.slave_address_list <= cfg_wdata_i;
      endcase
    end
  end

  rrsp_engine #(
    .MAX_SLAVES  (MAX_SLAVES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= step && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (advance && step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/rrsp_checker.sv =====
// rrsp_checker: port-level checks for round_robin_slave_poller, bound to the top level
// depends on rrsp_pkg and round_robin_slave_poller

module rrsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rrsp_pkg::out_item_t out_data_o
);

  // a held result keeps its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // input only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result side free");

  // a fresh result comes from an accepted beat that passed through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without an accepted beat");

endmodule

bind round_robin_slave_poller rrsp_checker u_rrsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/round_robin_slave_poller_tb.sv =====
// round_robin_slave_poller_tb: self-checking testbench for the round robin slave poller
// drives event beats and register writes, predicts every request and report beat
// depends on rrsp_pkg and round_robin_slave_poller
`timescale 1ns / 100ps

module round_robin_slave_poller_tb;
  import rrsp_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1950;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam out_item_t   NO_RES        = '0;

  typedef struct packed {
    bit                is_cfg;
    reg_e              reg_idx;
    logic [CFG_DW-1:0] reg_val;
    in_item_t          beat;
    bit                fixed;
    bit                has_res;
    out_item_t         res;
  } step_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_DW-1:0]    cfg_wdata_i = '0;

  // poller model state
  cfg_t        pol_cfg       = '0;
  phase_e      pol_phase     = PH_IDLE;
  logic [3:0]  pol_index     = '0;
  logic [31:0] pol_round_end = '0;
  bit          pol_seen      = 1'b0;
  bit          pol_online    = 1'b0;
  logic [15:0] pol_len       = '0;

  out_item_t   pending_results[$];
  out_item_t   got_want;
  step_row_t   dir_rows[$];
  int unsigned fail_cnt  = 0;
  int unsigned quiet_cnt = 0;
  bit          hold_req  = 1'b0;

  round_robin_slave_poller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit poller_advance(input in_item_t ev, output out_item_t res);
    int unsigned cnt;
    op_e         op;
    logic [7:0]  addr;
    logic [31:0] since;
    res   = '0;
    op    = op_e'(ev.opcode);
    cnt   = (pol_cfg.slave_count > MAX_SLAVES_DEF) ? MAX_SLAVES_DEF : pol_cfg.slave_count;
    addr  = pol_cfg.slave_address_list[8*pol_index[2:0] +: 8];
    since = ev.now_ms - pol_round_end;
    if (!pol_cfg.poll_enable) return 1'b0;
    if (op == OP_RESTART) begin
      pol_index     = '0;
      pol_phase     = PH_IDLE;
      pol_seen      = 1'b0;
      pol_round_end = ev.now_ms;
      return 1'b0;
    end
    if (op == OP_REPLY || op == OP_TIMEOUT) begin
      if (pol_phase != PH_WAIT || pol_seen) return 1'b0;
      if (op == OP_REPLY) begin
        if (!ev.reply_accepted) return 1'b0;
        pol_seen   = 1'b1;
        pol_online = 1'b1;
        pol_len    = ev.reply_length;
      end else begin
        pol_seen   = 1'b1;
        pol_online = 1'b0;
        pol_len    = '0;
      end
      return 1'b0;
    end
    if (cnt == 0) return 1'b0;
    case (pol_phase)
      PH_SEND: begin
        if (pol_index >= cnt) begin
          pol_round_end = ev.now_ms;
          pol_phase     = PH_IDLE;
          return 1'b0;
        end
        res.result_kind   = KIND_REQUEST;
        res.slave_address = addr;
        pol_seen          = 1'b0;
        pol_phase         = PH_WAIT;
        return 1'b1;
      end
      PH_WAIT: begin
        if (!pol_seen) return 1'b0;
        res.result_kind   = KIND_REPORT;
        res.slave_address = addr;
        res.slave_online  = pol_online;
        res.report_length = pol_len;
        pol_index         = pol_index + 4'd1;
        if (pol_index < cnt) begin
          pol_phase = PH_SEND;
        end else begin
          pol_round_end = ev.now_ms;
          pol_phase     = PH_IDLE;
        end
        return 1'b1;
      end
      default: begin
        if (since >= pol_cfg.round_interval) begin
          pol_index = '0;
          pol_phase = PH_SEND;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic in_item_t mk_beat(input op_e op, input logic [31:0] now,
                                       input logic acc, input logic [15:0] len);
    in_item_t b;
    b.opcode         = op;
    b.now_ms         = now;
    b.reply_accepted = acc;
    b.reply_length   = len;
    return b;
  endfunction

  function automatic out_item_t mk_res(input logic kind, input logic [7:0] addr,
                                       input logic online, input logic [15:0] len);
    out_item_t r;
    r.result_kind   = kind;
    r.slave_address = addr;
    r.slave_online  = online;
    r.report_length = len;
    return r;
  endfunction

  function automatic step_row_t ev_row(input op_e op, input logic [31:0] now,
                                       input logic acc, input logic [15:0] len);
    step_row_t row;
    row      = '0;
    row.beat = mk_beat(op, now, acc, len);
    return row;
  endfunction

  function automatic step_row_t fixed_row(input op_e op, input logic [31:0] now,
                                          input logic acc, input logic [15:0] len,
                                          input bit has, input out_item_t res);
    step_row_t row;
    row         = ev_row(op, now, acc, len);
    row.fixed   = 1'b1;
    row.has_res = has;
    row.res     = res;
    return row;
  endfunction

  function automatic step_row_t cfg_row(input reg_e idx, input logic [CFG_DW-1:0] val);
    step_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_event(input in_item_t beat, input bit fixed, input bit fixed_has,
                            input out_item_t fixed_res);
    out_item_t res;
    bit        has;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    has = poller_advance(beat, res);
    if (fixed) begin
      has = fixed_has;
      res = fixed_res;
    end
    if (has) pending_results.push_back(res);
  endtask

  task automatic idle_for(input int unsigned n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // drain all pending results, then let in-flight beats without a result retire
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_e idx, input logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_POLL_ENABLE:    pol_cfg.poll_enable        = val[0];
      REG_SLAVE_COUNT:    pol_cfg.slave_count        = val[COUNT_W-1:0];
      REG_ROUND_INTERVAL: pol_cfg.round_interval     = val[TIME_W-1:0];
      default:            pol_cfg.slave_address_list = val[LIST_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // result beat checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data_o);
        fail_cnt++;
      end else begin
        got_want = pending_results.pop_front();
        if (out_data_o.result_kind !== got_want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", got_want.result_kind,
                 out_data_o.result_kind);
          fail_cnt++;
        end
        if (out_data_o.slave_address !== got_want.slave_address) begin
          $error("slave_address: expected %h, got %h", got_want.slave_address,
                 out_data_o.slave_address);
          fail_cnt++;
        end
        if (out_data_o.slave_online !== got_want.slave_online) begin
          $error("slave_online: expected %0d, got %0d", got_want.slave_online,
                 out_data_o.slave_online);
          fail_cnt++;
        end
        if (out_data_o.report_length !== got_want.report_length) begin
          $error("report_length: expected %h, got %h", got_want.report_length,
                 out_data_o.report_length);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat, taken result or register write
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result side stall pattern
  initial begin : rx_stall
    int unsigned r;
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        n = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_stall_i <= 1'b0;
          n = $urandom_range(1, 20);
        end else if (r < 50) begin
          out_stall_i <= 1'b0;
          n = $urandom_range(50, 120);
        end else if (r < 88) begin
          out_stall_i <= 1'b1;
          n = $urandom_range(1, 3);
        end else if (r < 98) begin
          out_stall_i <= 1'b1;
          n = $urandom_range(4, 15);
        end else begin
          out_stall_i <= 1'b1;
          n = $urandom_range(30, 80);
        end
      end
      repeat (n - 1) @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned phase_no;
    int unsigned n_items;
    int unsigned k;
    int unsigned r;
    int unsigned live_items;
    bit          no_gaps;
    logic [31:0] clock_ms;
    logic [63:0] wval;
    in_item_t    beat;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    dir_rows.push_back(fixed_row(OP_TICK, 32'd0, 1'b1, 16'h0000, 1'b0, NO_RES));
    dir_rows.push_back(fixed_row(OP_RESTART, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0, NO_RES));
    dir_rows.push_back(cfg_row(REG_POLL_ENABLE, 64'd1));
    dir_rows.push_back(cfg_row(REG_SLAVE_COUNT, 64'd2));
    dir_rows.push_back(cfg_row(REG_ROUND_INTERVAL, 64'd0));
    dir_rows.push_back(cfg_row(REG_ADDRESS_LIST, 64'h0123_4567_89AB_FF00));
    dir_rows.push_back(fixed_row(OP_TICK, 32'd10, 1'b0, 16'h0000, 1'b0, NO_RES));
    dir_rows.push_back(fixed_row(OP_REPLY, 32'd10, 1'b1, 16'h1234, 1'b0, NO_RES));
    dir_rows.push_back(fixed_row(OP_TICK, 32'd11, 1'b0, 16'h0000, 1'b1,
                                 mk_res(KIND_REQUEST, 8'h00, 1'b0, 16'h0000)));
    dir_rows.push_back(fixed_row(OP_REPLY, 32'd11, 1'b0, 16'h5555, 1'b0, NO_RES));
    dir_rows.push_back(ev_row(OP_TICK, 32'd12, 1'b0, 16'h0000));
    dir_rows.push_back(ev_row(OP_REPLY, 32'd12, 1'b1, 16'hFFFF));
    dir_rows.push_back(ev_row(OP_TIMEOUT, 32'd12, 1'b0, 16'h0000));
    dir_rows.push_back(fixed_row(OP_TICK, 32'd13, 1'b0, 16'h0000, 1'b1,
                                 mk_res(KIND_REPORT, 8'h00, 1'b1, 16'hFFFF)));
    dir_rows.push_back(fixed_row(OP_TICK, 32'd14, 1'b0, 16'h0000, 1'b1,
                                 mk_res(KIND_REQUEST, 8'hFF, 1'b0, 16'h0000)));
    dir_rows.push_back(ev_row(OP_TIMEOUT, 32'd14, 1'b1, 16'hFFFF));
    dir_rows.push_back(fixed_row(OP_TICK, 32'd15, 1'b0, 16'h0000, 1'b1,
                                 mk_res(KIND_REPORT, 8'hFF, 1'b0, 16'h0000)));
    dir_rows.push_back(cfg_row(REG_ROUND_INTERVAL, 64'hFFFF_FFFF));
    dir_rows.push_back(ev_row(OP_TICK, 32'd20, 1'b0, 16'h0000));
    dir_rows.push_back(ev_row(OP_RESTART, 32'hFFFF_FFFF, 1'b0, 16'h0000));
    dir_rows.push_back(ev_row(OP_TICK, 32'hFFFF_FFFE, 1'b0, 16'h0000));
    dir_rows.push_back(ev_row(OP_TICK, 32'hFFFF_FFFF, 1'b0, 16'h0000));
    dir_rows.push_back(cfg_row(REG_SLAVE_COUNT, 64'd0));
    dir_rows.push_back(ev_row(OP_TICK, 32'd1, 1'b0, 16'h0000));
    dir_rows.push_back(cfg_row(REG_SLAVE_COUNT, 64'd15));
    dir_rows.push_back(ev_row(OP_REPLY, 32'd2, 1'b1, 16'h0000));
    dir_rows.push_back(ev_row(OP_TICK, 32'd3, 1'b0, 16'h0000));
    dir_rows.push_back(cfg_row(REG_SLAVE_COUNT, 64'd1));
    dir_rows.push_back(ev_row(OP_TICK, 32'd4, 1'b0, 16'h0000));
    dir_rows.push_back(cfg_row(REG_POLL_ENABLE, 64'd0));
    dir_rows.push_back(ev_row(OP_RESTART, 32'd0, 1'b1, 16'hFFFF));
    dir_rows.push_back(ev_row(OP_TICK, 32'd5, 1'b1, 16'hFFFF));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_event(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].has_res,
                   dir_rows[i].res);
        idle_for(gap_len());
      end
    end

    // random phases, each under its own register setting
    phase_no   = 0;
    live_items = 0;
    clock_ms   = 32'd100;
    while (live_items < RANDOM_ITEMS) begin
      settle();
      if (phase_no == 1) begin
        cfg_write(REG_POLL_ENABLE, 64'd1);
        cfg_write(REG_SLAVE_COUNT, 64'd8);
        cfg_write(REG_ROUND_INTERVAL, 64'd0);
        cfg_write(REG_ADDRESS_LIST, {$urandom, $urandom});
        hold_req = 1'b1;
      end else begin
        if (phase_no == 0 || $urandom_range(0, 3) != 0)
          cfg_write(REG_POLL_ENABLE, 64'($urandom_range(0, 9) != 0));
        if (phase_no == 0 || $urandom_range(0, 3) != 0) begin
          r    = $urandom_range(0, 99);
          wval = (r < 70) ? 64'($urandom_range(1, 8)) : 64'($urandom_range(0, 15));
          cfg_write(REG_SLAVE_COUNT, wval);
        end
        if (phase_no == 0 || $urandom_range(0, 3) != 0) begin
          r = $urandom_range(0, 99);
          if (r < 60)      wval = 64'($urandom_range(0, 8));
          else if (r < 80) wval = 64'($urandom_range(0, 40));
          else if (r < 90) wval = 64'hFFFF_FFFF;
          else             wval = 64'($urandom);
          cfg_write(REG_ROUND_INTERVAL, wval);
        end
        if (phase_no == 0 || $urandom_range(0, 3) != 0) begin
          r = $urandom_range(0, 99);
          if (r < 10)      wval = '0;
          else if (r < 20) wval = '1;
          else             wval = {$urandom, $urandom};
          cfg_write(REG_ADDRESS_LIST, wval);
        end
      end

      if (!pol_cfg.poll_enable) n_items = 12;
      else if (phase_no == 1)   n_items = 250;
      else                      n_items = $urandom_range(40, 160);
      no_gaps = ($urandom_range(0, 3) == 0);

      for (k = 0; k < n_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < 52)      beat.opcode = OP_TICK;
        else if (r < 78) beat.opcode = OP_REPLY;
        else if (r < 95) beat.opcode = OP_TIMEOUT;
        else             beat.opcode = OP_RESTART;
        r = $urandom_range(0, 99);
        if (r < 85)      clock_ms = clock_ms + $urandom_range(0, 3);
        else if (r < 95) clock_ms = clock_ms + $urandom_range(0, 50);
        else             clock_ms = $urandom;
        beat.now_ms         = clock_ms;
        beat.reply_accepted = ($urandom_range(0, 6) != 0);
        r = $urandom_range(0, 99);
        if (r < 10)      beat.reply_length = '0;
        else if (r < 20) beat.reply_length = '1;
        else             beat.reply_length = 16'($urandom);
        send_event(beat, 1'b0, 1'b0, NO_RES);
        if (pol_cfg.poll_enable) live_items++;
        if (!no_gaps) idle_for(gap_len());
      end
      phase_no++;
    end

    settle();
    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
